/* rtl/core/smpq_pkg.sv */
package smpq_pkg;

    localparam int DEF_CAPACITY      = 16;
    localparam int DEF_PRIO_WIDTH    = 16;
    localparam int DEF_PAYLOAD_WIDTH = 32;

    // command codes carried by the cmd field
    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_PUT   = 2'd1,
        CMD_TAKE  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // operation broadcast to every cell of the chain
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_PUT,
        OP_TAKE,
        OP_CLEAR
    } op_t;

    // control handed from one cell to its neighbors
    typedef struct packed {
        logic occ;   // cell holds an entry
        logic keep;  // entry stays in place on a put (priority not above the new one)
    } link_t;

endpackage

/* rtl/core/stable_min_priority_queue_core.sv */
// Stable minimum-priority queue built as a chain of CAPACITY cells, each
// holding one entry in ascending priority order from the head. Every input
// word (clear, put, take) is applied to all cells at once:
// on a put each cell compares its priority with the new one and either holds,
// takes the new entry, or takes its left neighbor's entry; on a take every
// cell takes its right neighbor's entry. Equal priorities leave in arrival
// order. The block accepts one input word per clock while in_ready is high and
// presents the result word in the cycle after acceptance in an output register;
// in_ready stays high while it is empty or draining, so back-to-back words flow
// at full rate whenever the result side takes every cycle. A take from an empty
// queue reports status 1 and a put into a full queue reports status 2; neither
// changes the contents. No clearing pass is needed after reset.
module stable_min_priority_queue_core #(
    parameter int CAPACITY      = smpq_pkg::DEF_CAPACITY,
    parameter int PRIO_WIDTH    = smpq_pkg::DEF_PRIO_WIDTH,
    parameter int PAYLOAD_WIDTH = smpq_pkg::DEF_PAYLOAD_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       cmd,
    input  logic [PRIO_WIDTH-1:0]            in_prio,
    input  logic [PAYLOAD_WIDTH-1:0]         in_payload,
    output logic                             res_valid,
    input  logic                             res_ready,
    output logic                             out_valid,
    output logic [PRIO_WIDTH-1:0]            out_prio,
    output logic [PAYLOAD_WIDTH-1:0]         out_payload,
    output logic [1:0]                       status,
    output logic                             is_empty,
    output logic [$clog2(CAPACITY+1)-1:0]    occupancy
);
    import smpq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic accept;
    op_t  op;

    // count of stored entries
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // result register
    logic                     res_valid_reg;
    logic                     res_valid_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [PRIO_WIDTH-1:0]    out_prio_reg;
    logic [PRIO_WIDTH-1:0]    out_prio_next;
    logic [PAYLOAD_WIDTH-1:0] out_payload_reg;
    logic [PAYLOAD_WIDTH-1:0] out_payload_next;
    status_t                  status_reg;
    status_t                  status_next;

    // chain wiring: index i is cell i; the ends are tied off inside the cell loop
    link_t                    cell_link    [CAPACITY];
    logic [PRIO_WIDTH-1:0]    cell_prio    [CAPACITY];
    logic [PAYLOAD_WIDTH-1:0] cell_payload [CAPACITY];

    // take a new word while the result register is free or draining
    assign in_ready = !res_valid_reg || res_ready;
    assign accept   = in_valid && in_ready;

    // decode the command into a chain operation and the result status
    always_comb
    begin
        op               = OP_HOLD;
        count_next       = count_reg;
        status_next      = ST_OK;
        out_valid_next   = 1'b0;
        out_prio_next    = '0;
        out_payload_next = '0;
        if (accept)
        begin
            unique case (cmd_t'(cmd))
                CMD_CLEAR:
                begin
                    op         = OP_CLEAR;
                    count_next = '0;
                end
                CMD_PUT:
                begin
                    if (count_reg == CAP_CNT)
                        status_next = ST_FULL;
                    else
                    begin
                        op         = OP_PUT;
                        count_next = count_reg + 1'b1;
                    end
                end
                CMD_TAKE:
                begin
                    if (count_reg == '0)
                        status_next = ST_EMPTY;
                    else
                    begin
                        op               = OP_TAKE;
                        count_next       = count_reg - 1'b1;
                        out_valid_next   = 1'b1;
                        out_prio_next    = cell_prio[0];
                        out_payload_next = cell_payload[0];
                    end
                end
                CMD_NONE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    // hold the result until taken, load a new one on accept
    always_comb
    begin
        priority if (accept)
            res_valid_next = 1'b1;
        else if (res_ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_valid_reg   <= out_valid_next;
            out_prio_reg    <= out_prio_next;
            out_payload_reg <= out_payload_next;
            status_reg      <= status_next;
        end
    end

    // occupancy and empty flag reflect the count after the word just taken
    logic [CNT_W-1:0] res_count_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
            res_count_reg <= count_next;
    end

    assign res_valid   = res_valid_reg;
    assign out_valid   = out_valid_reg;
    assign out_prio    = out_prio_reg;
    assign out_payload = out_payload_reg;
    assign status      = status_reg;
    assign occupancy   = res_count_reg;
    assign is_empty    = (res_count_reg == '0);

    // the chain of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        link_t                    l_link;
        logic [PRIO_WIDTH-1:0]    l_prio;
        logic [PAYLOAD_WIDTH-1:0] l_payload;
        link_t                    r_link;
        logic [PRIO_WIDTH-1:0]    r_prio;
        logic [PAYLOAD_WIDTH-1:0] r_payload;

        if (i == 0)
        begin : g_head
            // head cell: a non-keeping head always takes the new entry
            assign l_link    = '{occ: 1'b1, keep: 1'b1};
            assign l_prio    = '0;
            assign l_payload = '0;
        end
        else
        begin : g_mid
            assign l_link    = cell_link[i-1];
            assign l_prio    = cell_prio[i-1];
            assign l_payload = cell_payload[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            // tail cell empties on a take
            assign r_link    = '{occ: 1'b0, keep: 1'b0};
            assign r_prio    = '0;
            assign r_payload = '0;
        end
        else
        begin : g_body
            assign r_link    = cell_link[i+1];
            assign r_prio    = cell_prio[i+1];
            assign r_payload = cell_payload[i+1];
        end

        smpq_cell #(
            .PRIO_WIDTH    (PRIO_WIDTH),
            .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .op            (op),
            .new_prio      (in_prio),
            .new_payload   (in_payload),
            .left_link     (l_link),
            .left_prio     (l_prio),
            .left_payload  (l_payload),
            .right_link    (r_link),
            .right_prio    (r_prio),
            .right_payload (r_payload),
            .link          (cell_link[i]),
            .prio          (cell_prio[i]),
            .payload       (cell_payload[i])
        );
    end

endmodule

/* rtl/core/smpq_cell.sv */
module smpq_cell #(
    parameter int PRIO_WIDTH    = smpq_pkg::DEF_PRIO_WIDTH,
    parameter int PAYLOAD_WIDTH = smpq_pkg::DEF_PAYLOAD_WIDTH
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  smpq_pkg::op_t            op,
    input  logic [PRIO_WIDTH-1:0]    new_prio,
    input  logic [PAYLOAD_WIDTH-1:0] new_payload,
    input  smpq_pkg::link_t          left_link,
    input  logic [PRIO_WIDTH-1:0]    left_prio,
    input  logic [PAYLOAD_WIDTH-1:0] left_payload,
    input  smpq_pkg::link_t          right_link,
    input  logic [PRIO_WIDTH-1:0]    right_prio,
    input  logic [PAYLOAD_WIDTH-1:0] right_payload,
    output smpq_pkg::link_t          link,
    output logic [PRIO_WIDTH-1:0]    prio,
    output logic [PAYLOAD_WIDTH-1:0] payload
);
    import smpq_pkg::*;

    logic                     occ_reg;
    logic                     occ_next;
    logic [PRIO_WIDTH-1:0]    prio_reg;
    logic [PRIO_WIDTH-1:0]    prio_next;
    logic [PAYLOAD_WIDTH-1:0] payload_reg;
    logic [PAYLOAD_WIDTH-1:0] payload_next;

    assign link.occ  = occ_reg;
    assign link.keep = occ_reg & (prio_reg <= new_prio);
    assign prio      = prio_reg;
    assign payload   = payload_reg;

    always_comb
    begin
        occ_next     = occ_reg;
        prio_next    = prio_reg;
        payload_next = payload_reg;
        unique case (op)
            OP_HOLD:
            begin
            end
            OP_CLEAR:
            begin
                occ_next = 1'b0;
            end
            OP_TAKE:
            begin
                // advance everything one cell toward the head
                occ_next     = right_link.occ;
                prio_next    = right_prio;
                payload_next = right_payload;
            end
            OP_PUT:
            begin
                if (link.keep)
                begin
                end
                else if (left_link.keep)
                begin
                    occ_next     = 1'b1;
                    prio_next    = new_prio;
                    payload_next = new_payload;
                end
                else if (left_link.occ)
                begin
                    occ_next     = 1'b1;
                    prio_next    = left_prio;
                    payload_next = left_payload;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= 1'b0;
        else
            occ_reg <= occ_next;
    end

    always_ff @(posedge clk)
    begin
        prio_reg    <= prio_next;
        payload_reg <= payload_next;
    end

endmodule

/* rtl/core/smpq_checker.sv */
module smpq_checker #(
    parameter int CAPACITY      = smpq_pkg::DEF_CAPACITY,
    parameter int PRIO_WIDTH    = smpq_pkg::DEF_PRIO_WIDTH,
    parameter int PAYLOAD_WIDTH = smpq_pkg::DEF_PAYLOAD_WIDTH
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic                          out_valid,
    input logic [PRIO_WIDTH-1:0]         out_prio,
    input logic [PAYLOAD_WIDTH-1:0]      out_payload,
    input logic [1:0]                    status,
    input logic                          is_empty,
    input logic [$clog2(CAPACITY+1)-1:0] occupancy
);
    import smpq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // stalled result word holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(out_prio)
            && $stable(out_payload) && $stable(status) && $stable(occupancy))
        else $error("result word changed while stalled");

    // empty flag agrees with occupancy
    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (is_empty == (occupancy == '0)))
        else $error("is_empty disagrees with occupancy");

    // occupancy never exceeds the capacity
    a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (occupancy <= CNT_W'(CAPACITY)))
        else $error("occupancy above capacity");

    // a returned entry always comes with ok status
    a_take_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && out_valid |-> status == ST_OK)
        else $error("returned entry with error status");

    // an empty take leaves an empty queue, a full put leaves a full one
    a_err_state: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (status != ST_EMPTY || (is_empty && !out_valid))
            && (status != ST_FULL || occupancy == CNT_W'(CAPACITY)))
        else $error("error status inconsistent with occupancy");

endmodule

bind stable_min_priority_queue_core smpq_checker #(
    .CAPACITY      (CAPACITY),
    .PRIO_WIDTH    (PRIO_WIDTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
) u_smpq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .out_valid   (out_valid),
    .out_prio    (out_prio),
    .out_payload (out_payload),
    .status      (status),
    .is_empty    (is_empty),
    .occupancy   (occupancy)
);
